// ===== hw/rtl/tosc_pkg.sv =====
// Package for the tone oscillator with ADSR envelope.
// Holds widths, segment and register codes, the divider result type and the sine table.
// No dependencies.
package tosc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 24;
  localparam int LEN_W      = 24;
  localparam int LEVEL_W    = 32;
  localparam int CFG_W      = 24;
  localparam int MAG_W      = SAMPLE_W - 1;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int QBITS      = PHASE_W - 2;
  localparam logic [MAG_W-1:0] AMP = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    SEG_IDLE    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4,
    SEG_MUTE    = 3'd5
  } seg_t;

  typedef enum logic [2:0] {
    REG_WAVE_TYPE     = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_PULSE_WIDTH   = 3'd2,
    REG_PEAK_LEVEL    = 3'd3,
    REG_SUSTAIN_LEVEL = 3'd4,
    REG_ATTACK_LEN    = 3'd5,
    REG_DECAY_LEN     = 3'd6,
    REG_RELEASE_LEN   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_PULSE    = 2'd3
  } wave_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } div_res_t;

  typedef logic [MAG_W-1:0] sine_tab_t [SINE_DEPTH];

  localparam logic [63:0] COEF_Q30 [5] = '{
    64'd1686629713, 64'd693598669, 64'd85569305, 64'd5026996, 64'd172272
  };

  // Quarter sine, entry i is AMP*sin(pi/2*(i+0.5)/depth) from an odd polynomial in Q30.
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      u  = (64'(2 * i + 1) << 29) >> SINE_IDX_W;
      u2 = (u * u) >> 30;
      p  = u;
      s  = '0;
      for (int k = 0; k < 5; k++) begin
        t = (COEF_Q30[k] * p) >> 30;
        s = (k % 2 == 1) ? s - t : s + t;
        p = (p * u2) >> 30;
      end
      v = (s * 64'(AMP) + (64'd1 << 29)) >> 30;
      tab[i] = (v > 64'(AMP)) ? AMP : v[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== hw/rtl/tosc_div.sv =====
// Bit-serial restoring divider for the envelope slopes, one quotient bit per cycle.
// Depends on tosc_pkg.
module tosc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tosc_pkg::LEVEL_W-1:0] dividend,
  input  logic [tosc_pkg::LEN_W-1:0]   divisor,
  output tosc_pkg::div_res_t           res
);
  import tosc_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEN_W-1:0]   rem_r;
  logic [LEN_W-1:0]   dvs_r;
  logic [LEVEL_W-1:0] q_r;
  logic [LEN_W:0]     trial;
  logic               ge;

  assign trial = {rem_r, q_r[LEVEL_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LEVEL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? LEN_W'(trial - {1'b0, dvs_r}) : trial[LEN_W-1:0];
      q_r   <= {q_r[LEVEL_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;

endmodule

// ===== hw/rtl/tone_oscillator_with_adsr.sv =====
// Tone oscillator with ADSR envelope, top level.
// Depends on tosc_pkg and tosc_div.
//
// Each input beat is one sample tick: in_tuser is the start flag and in_tdata the note
// length in samples, read only on a start tick. A start tick resets the phase and begins
// a note. Each input beat yields exactly one output beat: out_tdata is the enveloped
// sample, out_tlast marks the last sample of a note and out_tuser is high while a note
// sounds. Registers are written through cfg_we, cfg_addr and cfg_wdata; the user
// must write them only while idle, as the block does not enforce it. The block works on
// one beat at a time. A tick that sounds runs the serial envelope multiply. A tick that
// enters a segment with a slope also runs the bit-serial divider, and a start tick may
// need two divides.
// The finished sample sits in the output register, so a stalled receiver only holds
// the next beat at its final step; in_tready stays low until that beat is stored.
// Reset clears the control state and loads the register defaults; the sine table is
// a constant and needs no fill.
module tone_oscillator_with_adsr (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tosc_pkg::LEN_W-1:0]     in_tdata,   // note_samples
  input  logic                           in_tuser,   // start_req
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tosc_pkg::SAMPLE_W-1:0]  out_tdata,  // sample
  output logic                           out_tlast,
  output logic                           out_tuser,  // active
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_addr,
  input  logic [tosc_pkg::CFG_W-1:0]     cfg_wdata
);
  import tosc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PREP = 9'b000000010,
    ST_CLIP = 9'b000000100,
    ST_NSEG = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_WAVE = 9'b000100000,
    ST_MUL  = 9'b001000000,
    ST_POST = 9'b010000000,
    ST_PUSH = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  logic [1:0]         wave_r;
  logic [PHASE_W-1:0] pstep_r, pwidth_r;
  logic [15:0]        peak_r, sus_r;
  logic [LEN_W-1:0]   att_r, dec_r, rel_r;

  logic               start_r;
  logic [LEN_W-1:0]   n_r;
  logic [PHASE_W-1:0] phase_r;
  logic [LEVEL_W-1:0] level_r, step_r;
  seg_t               seg_r, nfrom_r;
  logic [LEN_W-1:0]   left_r, cl_d_r, cl_s_r, cl_r_r, t_r, a_r;
  logic               ret_wave_r, endchk_r, step_neg_r;
  logic               neg_r, act_r;
  logic [MAG_W-1:0]   mc_r;
  logic [15:0]        mp_r;
  logic [31:0]        prod_r;
  logic [3:0]         mcnt_r;
  logic [SAMPLE_W-1:0] res_r;

  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_valid_r, out_last_r, out_user_r;

  logic               div_go;
  logic [LEVEL_W-1:0] div_a;
  logic [LEN_W-1:0]   div_b;
  div_res_t           div_res;

  tosc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r   <= WAVE_SINE;
      pstep_r  <= '0;
      pwidth_r <= 24'd8388608;
      peak_r   <= 16'hFFFF;
      sus_r    <= 16'h8000;
      att_r    <= '0;
      dec_r    <= '0;
      rel_r    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_WAVE_TYPE:     wave_r   <= cfg_wdata[1:0];
        REG_PHASE_STEP:    pstep_r  <= cfg_wdata[PHASE_W-1:0];
        REG_PULSE_WIDTH:   pwidth_r <= cfg_wdata[PHASE_W-1:0];
        REG_PEAK_LEVEL:    peak_r   <= cfg_wdata[15:0];
        REG_SUSTAIN_LEVEL: sus_r    <= cfg_wdata[15:0];
        REG_ATTACK_LEN:    att_r    <= cfg_wdata[LEN_W-1:0];
        REG_DECAY_LEN:     dec_r    <= cfg_wdata[LEN_W-1:0];
        REG_RELEASE_LEN:   rel_r    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic               in_acc;
  logic [LEN_W-1:0]   t_c, a_c, t2_c, d_c, s_c, att_nz, dec_nz;
  logic [LEVEL_W-1:0] tgt_c;
  seg_t               nsel;
  logic [LEN_W-1:0]   nlen;
  logic [QBITS-1:0]   rq;
  logic [1:0]         q;
  logic [SINE_IDX_W-1:0] sidx;
  logic [QBITS+MAG_W-1:0]   tri_x;
  logic [PHASE_W+MAG_W-1:0] saw_p, saw_n;
  logic [PHASE_W:0]         saw_w;
  logic [MAG_W-1:0]   mag_c;
  logic               neg_c;
  logic [LEVEL_W-1:0] lvl_c, gain_c;
  logic [MAG_W+1:0]   madd;

  assign in_acc = in_tvalid && in_tready;
  assign t_c    = n_r - rel_r;
  assign a_c    = (att_r < t_c) ? att_r : t_c;
  assign t2_c   = t_r - a_r;
  assign d_c    = (dec_r < t2_c) ? dec_r : t2_c;
  assign s_c    = t2_c - d_c;
  assign att_nz = (att_r == '0) ? LEN_W'(1) : att_r;
  assign dec_nz = (dec_r == '0) ? LEN_W'(1) : dec_r;
  assign tgt_c  = {sus_r, 16'h0000};

  always_comb begin
    nsel = SEG_IDLE;
    nlen = '0;
    if (nfrom_r == SEG_ATTACK && cl_d_r != '0) begin
      nsel = SEG_DECAY;
      nlen = cl_d_r;
    end else if ((nfrom_r == SEG_ATTACK || nfrom_r == SEG_DECAY) && cl_s_r != '0) begin
      nsel = SEG_SUSTAIN;
      nlen = cl_s_r;
    end else if ((nfrom_r == SEG_ATTACK || nfrom_r == SEG_DECAY ||
                  nfrom_r == SEG_SUSTAIN) && cl_r_r != '0) begin
      nsel = SEG_RELEASE;
      nlen = cl_r_r;
    end
  end

  assign q     = phase_r[PHASE_W-1 -: 2];
  assign rq    = phase_r[QBITS-1:0];
  assign sidx  = q[0] ? ~rq[QBITS-1 -: SINE_IDX_W] : rq[QBITS-1 -: SINE_IDX_W];
  assign tri_x = {rq, {MAG_W{1'b0}}} - (QBITS+MAG_W)'(rq);
  assign saw_p = {phase_r, {MAG_W{1'b0}}} - (PHASE_W+MAG_W)'(phase_r);
  assign saw_w = {1'b1, {PHASE_W{1'b0}}} - {1'b0, phase_r};
  assign saw_n = {saw_w[PHASE_W-1:0], {MAG_W{1'b0}}} - (PHASE_W+MAG_W)'(saw_w);

  always_comb begin
    mag_c = AMP;
    neg_c = 1'b0;
    case (wave_t'(wave_r))
      WAVE_SINE: begin
        mag_c = SINE_TAB[sidx];
        neg_c = q[1];
      end
      WAVE_TRIANGLE: begin
        mag_c = q[0] ? AMP - tri_x[QBITS+MAG_W-1 -: MAG_W] : tri_x[QBITS+MAG_W-1 -: MAG_W];
        neg_c = q[1];
      end
      WAVE_SAWTOOTH: begin
        neg_c = phase_r[PHASE_W-1];
        mag_c = neg_c ? saw_n[PHASE_W+MAG_W-2 -: MAG_W] : saw_p[PHASE_W+MAG_W-2 -: MAG_W];
      end
      default: begin
        mag_c = AMP;
        neg_c = phase_r >= pwidth_r;
      end
    endcase
  end

  always_comb begin
    lvl_c  = level_r;
    gain_c = '0;
    case (seg_r)
      SEG_ATTACK: begin
        gain_c = level_r;
        lvl_c  = level_r + step_r;
      end
      SEG_DECAY: begin
        lvl_c  = level_r + step_r;
        gain_c = lvl_c;
      end
      SEG_SUSTAIN: gain_c = level_r;
      SEG_RELEASE: begin
        gain_c = level_r;
        lvl_c  = (level_r >= step_r) ? level_r - step_r : '0;
      end
      default: gain_c = '0;
    endcase
  end

  assign madd = {1'b0, prod_r[31:16]} + (mp_r[0] ? (MAG_W+2)'(mc_r) : '0);

  always_comb begin
    st_nxt = st_r;
    div_go = 1'b0;
    div_a  = '0;
    div_b  = '0;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_PREP;
      ST_PREP: begin
        if (!start_r) st_nxt = ST_WAVE;
        else if (n_r == '0 || rel_r >= n_r) st_nxt = ST_WAVE;
        else st_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        if (a_r != '0) begin
          div_go = 1'b1;
          div_a  = {peak_r, 16'h0000};
          div_b  = att_nz;
          st_nxt = ST_DIV;
        end else begin
          st_nxt = ST_NSEG;
        end
      end
      ST_NSEG: begin
        if (nsel == SEG_DECAY) begin
          div_go = 1'b1;
          div_a  = (tgt_c >= level_r) ? tgt_c - level_r : level_r - tgt_c;
          div_b  = dec_nz;
          st_nxt = ST_DIV;
        end else if (nsel == SEG_RELEASE) begin
          div_go = 1'b1;
          div_a  = level_r;
          div_b  = nlen;
          st_nxt = ST_DIV;
        end else begin
          st_nxt = ret_wave_r ? ST_WAVE : ST_PUSH;
        end
      end
      ST_DIV:  if (div_res.done) st_nxt = ret_wave_r ? ST_WAVE : ST_PUSH;
      ST_WAVE: st_nxt = (seg_r == SEG_IDLE) ? ST_PUSH : ST_MUL;
      ST_MUL:  if (mcnt_r == 4'd15) st_nxt = ST_POST;
      ST_POST: st_nxt = (left_r == LEN_W'(1)) ? ST_NSEG : ST_PUSH;
      ST_PUSH: if (!out_valid_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      phase_r <= '0;
      level_r <= '0;
      step_r  <= '0;
      seg_r   <= SEG_IDLE;
      left_r  <= '0;
      cl_d_r  <= '0;
      cl_s_r  <= '0;
      cl_r_r  <= '0;
      endchk_r <= 1'b0;
      act_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && out_tready && st_r != ST_PUSH) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            start_r  <= in_tuser;
            n_r      <= in_tdata;
            endchk_r <= 1'b0;
            act_r    <= 1'b0;
            res_r    <= '0;
          end
        end
        ST_PREP: begin
          ret_wave_r <= 1'b1;
          nfrom_r    <= SEG_ATTACK;
          if (start_r) begin
            phase_r <= '0;
            level_r <= '0;
            step_r  <= '0;
            cl_d_r  <= '0;
            cl_s_r  <= '0;
            cl_r_r  <= '0;
            t_r     <= t_c;
            a_r     <= a_c;
            if (n_r == '0) begin
              seg_r  <= SEG_IDLE;
              left_r <= '0;
            end else if (rel_r >= n_r) begin
              seg_r  <= SEG_MUTE;
              left_r <= n_r;
            end
          end
        end
        ST_CLIP: begin
          cl_d_r <= d_c;
          cl_s_r <= s_c;
          cl_r_r <= rel_r;
          if (a_r != '0) begin
            seg_r      <= SEG_ATTACK;
            left_r     <= a_r;
            step_neg_r <= 1'b0;
          end
        end
        ST_NSEG: begin
          seg_r      <= nsel;
          left_r     <= nlen;
          step_neg_r <= (nsel == SEG_DECAY) && (tgt_c < level_r);
          if (nsel == SEG_SUSTAIN) level_r <= tgt_c;
          if (nsel == SEG_SUSTAIN || nsel == SEG_IDLE) step_r <= '0;
        end
        ST_DIV: begin
          if (div_res.done) step_r <= step_neg_r ? '0 - div_res.quot : div_res.quot;
        end
        ST_WAVE: begin
          if (seg_r != SEG_IDLE) begin
            act_r   <= 1'b1;
            level_r <= lvl_c;
            neg_r   <= neg_c;
            mc_r    <= mag_c;
            mp_r    <= gain_c[31:16];
            prod_r  <= '0;
            mcnt_r  <= '0;
          end
        end
        ST_MUL: begin
          prod_r <= {madd[MAG_W+1:0], prod_r[15:MAG_W+2-16]};
          mp_r   <= {1'b0, mp_r[15:1]};
          mcnt_r <= mcnt_r + 1'b1;
        end
        ST_POST: begin
          res_r   <= neg_r ? '0 - prod_r[31:16] : prod_r[31:16];
          left_r  <= left_r - 1'b1;
          phase_r <= phase_r + pstep_r;
          if (left_r == LEN_W'(1)) begin
            nfrom_r    <= seg_r;
            ret_wave_r <= 1'b0;
            endchk_r   <= 1'b1;
          end
        end
        ST_PUSH: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_last_r  <= endchk_r && (seg_r == SEG_IDLE);
            out_user_r  <= act_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("note end flagged on an inactive beat");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero sample while no note sounds");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while one is in work");

  a_seg_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_WAVE && seg_r != SEG_IDLE |-> left_r != '0)
    else $error("sounding segment with no samples left");

endmodule
